>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks used by the RTL module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// expr must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

>>> rtl/tlnef_pkg.sv
// ----------------------------------------------------------------------------
// tlnef_pkg
// Types, character codes and limits for the line numbering and escape filter.
// ----------------------------------------------------------------------------
package tlnef_pkg;

   localparam int COUNT_W        = 20;
   localparam int BCD_DIGITS     = 7;   // decimal digits of the 20-bit line count
   localparam int DIGITS_DEFAULT = 6;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   localparam logic [7:0] CHR_TAB    = 8'h09;
   localparam logic [7:0] CHR_NL     = 8'h0A;
   localparam logic [7:0] CHR_SPACE  = 8'h20;
   localparam logic [7:0] CHR_DOLLAR = 8'h24;
   localparam logic [7:0] CHR_QMARK  = 8'h3F;
   localparam logic [7:0] CHR_I      = 8'h49;
   localparam logic [7:0] CHR_CARET  = 8'h5E;
   localparam logic [7:0] CHR_DEL    = 8'h7F;
   localparam logic [3:0] CHR_DIGIT_HI = 4'h3;   // upper nibble of '0'..'9'
   localparam logic [7:0] CTRL_LIMIT  = 8'd32;
   localparam logic [7:0] CTRL_OFFSET = 8'd64;

   typedef enum logic [2:0] {
      CSR_SQUEEZE_BLANK    = 3'd0,
      CSR_SHOW_ENDS        = 3'd1,
      CSR_SHOW_TABS        = 3'd2,
      CSR_SHOW_NONPRINTING = 3'd3,
      CSR_NUMBER_NONBLANK  = 3'd4,
      CSR_NUMBER_ALL       = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic squeeze_blank;
      logic show_ends;
      logic show_tabs;
      logic show_nonprinting;
      logic number_nonblank;
      logic number_all;
   } cfg_type;

   // Saturation point: 10^digits - 1, capped at the counter maximum
   function automatic logic [COUNT_W-1:0] count_limit(input int digits);
      longint m;
      m = 1;
      for (int i = 0; i < digits && m <= longint'(COUNT_MAX); i++) begin
         m = m * 10;
      end
      m = m - 1;
      if (m > longint'(COUNT_MAX)) begin
         m = longint'(COUNT_MAX);
      end
      return m[COUNT_W-1:0];
   endfunction

endpackage

>>> rtl/text_line_number_escape_filter.sv
// ----------------------------------------------------------------------------
// text_line_number_escape_filter: cat-style line numbering and escaping
// An accepted item is loaded into the sequence buffer, then each byte moves to
// the registered output. One output byte per cycle while rsp_ready is high; a
// new item is taken as the last byte of the one before leaves. Sync reset: options off.
// ----------------------------------------------------------------------------
module text_line_number_escape_filter
   import tlnef_pkg::*;
#(
   parameter int NUMBER_DIGITS = DIGITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   // input channel
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_first_of_file,
   // result channel
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_of_run,
   // configuration
   input  logic       csr_we,
   input  logic [2:0] csr_index,
   input  logic       csr_wdata
);

`include "assert_macros.svh"

   // Sequence buffer layout when numbering: digits, tab, char0, char1.
   // Without a number: char0, char1 at the head.
   localparam int SEQ_LEN = NUMBER_DIGITS + 3;
   localparam int CNT_W   = $clog2(SEQ_LEN + 1);
   localparam logic [COUNT_W-1:0] COUNT_LIMIT = count_limit(NUMBER_DIGITS);

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_SQUEEZE_BLANK:    cfg_in.squeeze_blank    = csr_wdata;
            CSR_SHOW_ENDS:        cfg_in.show_ends        = csr_wdata;
            CSR_SHOW_TABS:        cfg_in.show_tabs        = csr_wdata;
            CSR_SHOW_NONPRINTING: cfg_in.show_nonprinting = csr_wdata;
            CSR_NUMBER_NONBLANK:  cfg_in.number_nonblank  = csr_wdata;
            CSR_NUMBER_ALL:       cfg_in.number_all       = csr_wdata;
            default:              cfg_in = cfg_ff;   // unused indexes
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Line state. The count is kept twice: binary for the saturation
   // compare, and BCD so the printed digits need no conversion.
   // ---------------------------------------------------------------------
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [3:0]         bcd_ff [BCD_DIGITS];
   logic [3:0]         bcd_in [BCD_DIGITS];
   logic               at_line_start_ff, at_line_start_in;
   logic               prev_blank_ff, prev_blank_in;

   // ---------------------------------------------------------------------
   // Output sequence buffer (shifts toward index 0 as bytes go out) and
   // the registered result.
   // ---------------------------------------------------------------------
   logic [7:0]       seq_ff [SEQ_LEN];
   logic [7:0]       seq_in [SEQ_LEN];
   logic [CNT_W-1:0] seq_cnt_ff, seq_cnt_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_byte_ff;
   logic             rsp_last_ff;

   // handshake
   logic out_load;    // output register free this cycle
   logic emit;        // a buffered byte moves to the output register
   logic accept;      // input item taken

   assign out_load  = !rsp_valid_ff || rsp_ready;
   assign emit      = (seq_cnt_ff != '0) && out_load;
   // New item may enter when the buffer is empty or its last byte leaves now
   assign req_ready = (seq_cnt_ff == '0) || ((seq_cnt_ff == CNT_W'(1)) && out_load);
   assign accept    = req_valid && req_ready;

   // ---------------------------------------------------------------------
   // Per-item decode
   // ---------------------------------------------------------------------
   logic       is_nl, is_tab;
   logic       prev_blank_eff;  // after file-start clear
   logic       squeeze;         // empty line dropped, no output
   logic       numbered;        // this item carries a line number prefix
   logic [7:0] chr0, chr1;
   logic       two_chr;

   assign is_nl          = (req_in_byte == CHR_NL);
   assign is_tab         = (req_in_byte == CHR_TAB);
   assign prev_blank_eff = prev_blank_ff && !req_first_of_file;
   assign squeeze        = at_line_start_ff && cfg_ff.squeeze_blank
                           && prev_blank_eff && is_nl;
   // number_nonblank wins over number_all
   assign numbered       = at_line_start_ff
                           && (cfg_ff.number_nonblank ? !is_nl : cfg_ff.number_all);

   // Escape selection: ends before tabs before nonprinting
   always_comb begin
      chr0    = req_in_byte;
      chr1    = req_in_byte;
      two_chr = 1'b0;
      priority if (cfg_ff.show_ends && is_nl) begin
         chr0    = CHR_DOLLAR;
         chr1    = CHR_NL;
         two_chr = 1'b1;
      end else if (cfg_ff.show_tabs && is_tab) begin
         chr0    = CHR_CARET;
         chr1    = CHR_I;
         two_chr = 1'b1;
      end else if (cfg_ff.show_nonprinting && (req_in_byte < CTRL_LIMIT)
                   && !is_nl && !is_tab) begin
         chr0    = CHR_CARET;
         chr1    = req_in_byte + CTRL_OFFSET;
         two_chr = 1'b1;
      end else if (cfg_ff.show_nonprinting && (req_in_byte == CHR_DEL)) begin
         chr0    = CHR_CARET;
         chr1    = CHR_QMARK;
         two_chr = 1'b1;
      end else begin
         chr0    = req_in_byte;
      end
   end

   // ---------------------------------------------------------------------
   // Line number characters. Column j counts from the right; a column is
   // blank when it and every higher BCD digit are zero (the count is never 0,
   // so column 0 always shows a digit).
   // ---------------------------------------------------------------------
   logic [BCD_DIGITS-1:0] upper_zero;
   logic [7:0]            col_chr [NUMBER_DIGITS];

   assign upper_zero[BCD_DIGITS-1] = (bcd_ff[BCD_DIGITS-1] == 4'd0);
   for (genvar k = 0; k < BCD_DIGITS - 1; k++) begin : g_zero
      assign upper_zero[k] = upper_zero[k+1] && (bcd_ff[k] == 4'd0);
   end

   for (genvar j = 0; j < NUMBER_DIGITS; j++) begin : g_col
      if (j == 0) begin : g_units
         assign col_chr[j] = {CHR_DIGIT_HI, bcd_ff[j]};
      end else if (j < BCD_DIGITS) begin : g_mid
         assign col_chr[j] = upper_zero[j] ? CHR_SPACE : {CHR_DIGIT_HI, bcd_ff[j]};
      end else begin : g_high
         assign col_chr[j] = CHR_SPACE;   // count never reaches this column
      end
   end

   // ---------------------------------------------------------------------
   // Buffer contents for a fresh item
   // ---------------------------------------------------------------------
   logic [7:0] load_chr [SEQ_LEN];

   for (genvar p = 0; p < SEQ_LEN; p++) begin : g_load
      logic [7:0] num_chr;
      logic [7:0] plain_chr;
      if (p < NUMBER_DIGITS) begin : g_digit
         assign num_chr = col_chr[NUMBER_DIGITS-1-p];
      end else if (p == NUMBER_DIGITS) begin : g_tab
         assign num_chr = CHR_TAB;
      end else if (p == NUMBER_DIGITS + 1) begin : g_c0
         assign num_chr = chr0;
      end else begin : g_c1
         assign num_chr = chr1;
      end
      if (p == 0) begin : g_p0
         assign plain_chr = chr0;
      end else if (p == 1) begin : g_p1
         assign plain_chr = chr1;
      end else begin : g_pz
         assign plain_chr = '0;
      end
      assign load_chr[p] = numbered ? num_chr : plain_chr;
   end

   // ---------------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------------
   logic bump;   // line number advances

   assign bump = accept && !squeeze && numbered && (count_ff < COUNT_LIMIT);

   always_comb begin
      logic carry;
      carry    = 1'b1;
      count_in = count_ff;
      for (int i = 0; i < BCD_DIGITS; i++) begin
         bcd_in[i] = bcd_ff[i];
      end
      if (bump) begin
         count_in = count_ff + COUNT_W'(1);
         for (int i = 0; i < BCD_DIGITS; i++) begin
            if (carry) begin
               if (bcd_ff[i] == 4'd9) begin
                  bcd_in[i] = 4'd0;
               end else begin
                  bcd_in[i] = bcd_ff[i] + 4'd1;
                  carry     = 1'b0;
               end
            end
         end
      end
   end

   always_comb begin
      at_line_start_in = at_line_start_ff;
      prev_blank_in    = prev_blank_ff;
      if (accept && !squeeze) begin
         at_line_start_in = is_nl;
         prev_blank_in    = at_line_start_ff ? is_nl : prev_blank_eff;
      end
   end

   // Buffer: load a new item, else shift out one byte
   always_comb begin
      seq_cnt_in = seq_cnt_ff;
      for (int p = 0; p < SEQ_LEN; p++) begin
         seq_in[p] = seq_ff[p];
      end
      if (accept && !squeeze) begin
         for (int p = 0; p < SEQ_LEN; p++) begin
            seq_in[p] = load_chr[p];
         end
         seq_cnt_in = (numbered ? CNT_W'(NUMBER_DIGITS + 1) : CNT_W'(0))
                      + (two_chr ? CNT_W'(2) : CNT_W'(1));
      end else if (emit) begin
         for (int p = 0; p < SEQ_LEN - 1; p++) begin
            seq_in[p] = seq_ff[p+1];
         end
         seq_in[SEQ_LEN-1] = '0;
         seq_cnt_in = seq_cnt_ff - CNT_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff           <= '0;
         count_ff         <= COUNT_W'(1);
         for (int i = 0; i < BCD_DIGITS; i++) begin
            bcd_ff[i] <= (i == 0) ? 4'd1 : 4'd0;
         end
         at_line_start_ff <= 1'b1;
         prev_blank_ff    <= 1'b0;
         seq_cnt_ff       <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         cfg_ff           <= cfg_in;
         count_ff         <= count_in;
         for (int i = 0; i < BCD_DIGITS; i++) begin
            bcd_ff[i] <= bcd_in[i];
         end
         at_line_start_ff <= at_line_start_in;
         prev_blank_ff    <= prev_blank_in;
         seq_cnt_ff       <= seq_cnt_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      for (int p = 0; p < SEQ_LEN; p++) begin
         seq_ff[p] <= seq_in[p];
      end
      if (emit) begin
         rsp_byte_ff <= seq_ff[0];
         rsp_last_ff <= (seq_cnt_ff == CNT_W'(1));
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_last_of_run = rsp_last_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   logic [BCD_DIGITS-1:0] bcd_ok;

   for (genvar k = 0; k < BCD_DIGITS; k++) begin : g_bcd_ok
      assign bcd_ok[k] = (bcd_ff[k] <= 4'd9);
   end

   `ASSERT_PROP(a_count_range, clock, reset,
      (count_ff != '0) && (count_ff <= COUNT_LIMIT), "line count out of range")
   `ASSERT_PROP(a_bcd_digits, clock, reset, &bcd_ok, "BCD digit above nine")
   `ASSERT_NEVER(a_stall_blocks_input, clock, reset,
      (seq_cnt_ff != '0) && rsp_valid_ff && !rsp_ready && req_ready,
      "input taken while output stalled with bytes pending")
   `ASSERT_PROP(a_drained_is_last, clock, reset,
      (rsp_valid_ff && (seq_cnt_ff == '0)) |-> rsp_last_ff,
      "buffer drained but held byte not marked last")

endmodule

>>> dv/text_line_number_escape_filter_test.sv
// ----------------------------------------------------------------------------
// text_line_number_escape_filter_test
// Self-checking bench for the cat-style filter. A behavioral predictor formats
// each accepted text byte into the expected output bytes. A checker process
// compares every output item against them in order. Directed cases cover byte
// extremes, every escape form, both numbering modes, blank squeezing and file
// starts. Random text runs under several option settings and idle patterns.
// ----------------------------------------------------------------------------
module text_line_number_escape_filter_test;
   import tlnef_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int          NUM_COLS   = DIGITS_DEFAULT;
   // 10^6 - 1, which fits below the 20-bit counter maximum
   localparam logic [19:0] LINE_LIMIT = 20'd999999;
   localparam logic [7:0]  CHR_ZERO   = 8'h30;
   localparam logic [7:0]  CHR_A      = 8'h41;
   localparam int          RUN_ITEMS  = 42;   // items per option setting in random text

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } out_item_type;

   // ---------------------------------------------------------------------------
   // DUT signals; every input starts at a known value
   // ---------------------------------------------------------------------------
   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_first_of_file = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_last_of_run;
   logic       csr_we = 1'b0;
   logic [2:0] csr_index = CSR_SQUEEZE_BLANK;
   logic       csr_wdata = 1'b0;

   text_line_number_escape_filter dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_in_byte       (req_in_byte),
      .req_first_of_file (req_first_of_file),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_last_of_run   (rsp_last_of_run),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // ---------------------------------------------------------------------------
   // Predictor state: our own copy of options, line counter and line position
   // ---------------------------------------------------------------------------
   cfg_type     opts = '0;
   logic [19:0] line_cnt = 20'd1;
   logic        at_start = 1'b1;
   logic        prev_blank = 1'b0;

   out_item_type pending_out_bytes[$];  // formatted bytes still owed by the DUT
   int          errors = 0;
   int          tx_idle_pct = 0;        // chance per cycle that the sender holds off
   int          rx_idle_pct = 0;        // chance per cycle that the receiver stalls

   initial begin
      forever #1 clock = ~clock;
   end

   // Safety net: far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Predictor: format one accepted text byte into the expected output items
   // ---------------------------------------------------------------------------
   task automatic format_char(input logic [7:0] ch, input logic fof);
      logic [7:0]  run_bytes[$];
      logic [7:0]  digits[NUM_COLS];
      logic [19:0] v;
      logic        is_nl;
      is_nl = (ch == CHR_NL);
      // a new file forgets the previous blank line, not the line position
      if (fof) prev_blank = 1'b0;
      if (at_start) begin
         // repeated empty line: dropped, nothing else changes
         if (opts.squeeze_blank && prev_blank && is_nl) return;
         prev_blank = is_nl;
         if ((opts.number_nonblank && !is_nl) ||
             (!opts.number_nonblank && opts.number_all)) begin
            v = line_cnt;
            for (int i = NUM_COLS - 1; i >= 0; i--) begin
               if (v == 0 && i != NUM_COLS - 1) begin
                  digits[i] = CHR_SPACE;
               end else begin
                  digits[i] = CHR_ZERO + 8'(v % 10);
               end
               v = v / 10;
            end
            foreach (digits[i]) run_bytes.push_back(digits[i]);
            run_bytes.push_back(CHR_TAB);
            if (line_cnt < LINE_LIMIT) line_cnt = line_cnt + 20'd1;
         end
      end
      // precedence: ends for newline, then tabs, then nonprinting
      if (opts.show_ends && is_nl) begin
         run_bytes.push_back(CHR_DOLLAR);
         run_bytes.push_back(CHR_NL);
      end else if (opts.show_tabs && ch == CHR_TAB) begin
         run_bytes.push_back(CHR_CARET);
         run_bytes.push_back(CHR_I);
      end else if (opts.show_nonprinting && ch < CTRL_LIMIT && !is_nl && ch != CHR_TAB) begin
         run_bytes.push_back(CHR_CARET);
         run_bytes.push_back(ch + CTRL_OFFSET);
      end else if (opts.show_nonprinting && ch == CHR_DEL) begin
         run_bytes.push_back(CHR_CARET);
         run_bytes.push_back(CHR_QMARK);
      end else begin
         run_bytes.push_back(ch);
      end
      at_start = is_nl;
      foreach (run_bytes[i]) begin
         pending_out_bytes.push_back('{data: run_bytes[i], last: (i == run_bytes.size() - 1)});
      end
   endtask

   // ---------------------------------------------------------------------------
   // Output checker and receiver stalls
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      out_item_type exp_item;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_out_bytes.size() == 0) begin
            $display("%0t unexpected item: got byte %h last %b",
                     $time, rsp_out_byte, rsp_last_of_run);
            errors++;
         end else begin
            exp_item = pending_out_bytes.pop_front();
            if (rsp_out_byte !== exp_item.data) begin
               $display("%0t out_byte mismatch: expected %h actual %h",
                        $time, exp_item.data, rsp_out_byte);
               errors++;
            end
            if (rsp_last_of_run !== exp_item.last) begin
               $display("%0t last_of_run mismatch: expected %b actual %b",
                        $time, exp_item.last, rsp_last_of_run);
               errors++;
            end
         end
      end
      rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
   end

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------

   // Present one item, hold it until taken, then predict. Valid stays high
   // into the next call unless that call starts with a gap.
   task automatic send_char(input logic [7:0] ch, input logic fof);
      int gap;
      gap = 0;
      while ($urandom_range(0, 99) < tx_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_in_byte       <= ch;
      req_first_of_file <= fof;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      format_char(ch, fof);
   endtask

   // Wait until every owed byte is out; a squeezed byte may still be in flight
   task automatic drain;
      req_valid <= 1'b0;
      while (pending_out_bytes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_SQUEEZE_BLANK:    opts.squeeze_blank    = val;
         CSR_SHOW_ENDS:        opts.show_ends        = val;
         CSR_SHOW_TABS:        opts.show_tabs        = val;
         CSR_SHOW_NONPRINTING: opts.show_nonprinting = val;
         CSR_NUMBER_NONBLANK:  opts.number_nonblank  = val;
         CSR_NUMBER_ALL:       opts.number_all       = val;
         default: ;
      endcase
   endtask

   // All six registers are written every time, only while the block is idle
   task automatic set_options(input cfg_type c);
      drain();
      write_csr(CSR_SQUEEZE_BLANK,    c.squeeze_blank);
      write_csr(CSR_SHOW_ENDS,        c.show_ends);
      write_csr(CSR_SHOW_TABS,        c.show_tabs);
      write_csr(CSR_SHOW_NONPRINTING, c.show_nonprinting);
      write_csr(CSR_NUMBER_NONBLANK,  c.number_nonblank);
      write_csr(CSR_NUMBER_ALL,       c.number_all);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Text-like byte mix: lots of newlines so line logic is exercised
   function automatic logic [7:0] pick_text_char();
      int r;
      r = $urandom_range(0, 99);
      if (r < 25)      return CHR_NL;
      else if (r < 33) return CHR_TAB;
      else if (r < 43) return 8'($urandom_range(0, 31));
      else if (r < 47) return CHR_DEL;
      else if (r < 57) return 8'($urandom_range(128, 255));
      else if (r < 62) return 8'($urandom_range(0, 255));
      else             return 8'($urandom_range(32, 126));
   endfunction

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Options off: every byte passes through, extremes included
   task automatic test_plain_bytes;
      set_options('0);
      send_char(8'h00, 1'b1);
      send_char(8'hFF, 1'b0);
      send_char(CHR_DEL, 1'b0);
      send_char(CHR_TAB, 1'b0);
      send_char(8'h80, 1'b0);
      send_char(CHR_NL, 1'b0);
   endtask

   // Each escape form, then nonprinting alone leaving newline and tab alone
   task automatic test_escape_forms;
      set_options(cfg_type'{show_ends: 1'b1, show_tabs: 1'b1, show_nonprinting: 1'b1,
                            default: 1'b0});
      send_char(CHR_NL, 1'b0);
      send_char(CHR_TAB, 1'b0);
      send_char(8'h01, 1'b0);
      send_char(8'h1F, 1'b0);
      send_char(CHR_DEL, 1'b0);
      send_char(8'h80, 1'b0);
      send_char(CHR_A, 1'b0);
      set_options(cfg_type'{show_nonprinting: 1'b1, default: 1'b0});
      send_char(CHR_TAB, 1'b0);
      send_char(CHR_NL, 1'b0);
   endtask

   // Nonblank numbering wins over numbering all; then number every line
   task automatic test_line_numbers;
      set_options(cfg_type'{number_nonblank: 1'b1, number_all: 1'b1, default: 1'b0});
      send_char(CHR_A, 1'b0);
      send_char(CHR_NL, 1'b0);
      send_char(CHR_NL, 1'b0);
      send_char(CHR_A, 1'b0);
      set_options(cfg_type'{number_all: 1'b1, show_ends: 1'b1, default: 1'b0});
      send_char(CHR_NL, 1'b0);
   endtask

   // Repeated blank lines dropped; a file start forgets the blank line but
   // not the line position
   task automatic test_blank_squeeze;
      set_options(cfg_type'{squeeze_blank: 1'b1, number_all: 1'b1, default: 1'b0});
      send_char(CHR_NL, 1'b0);
      send_char(CHR_NL, 1'b0);
      send_char(CHR_NL, 1'b0);
      send_char(CHR_NL, 1'b1);
      send_char(CHR_A, 1'b0);
      send_char(CHR_NL, 1'b1);
   endtask

   // Random text under all-on, all-off and two random option settings
   task automatic test_random_text;
      cfg_type c;
      for (int k = 0; k < 4; k++) begin
         if (k == 0)      c = '1;
         else if (k == 1) c = '0;
         else             c = cfg_type'(6'($urandom_range(0, 63)));
         set_options(c);
         repeat (RUN_ITEMS) begin
            send_char(pick_text_char(), ($urandom_range(0, 99) < 4));
         end
      end
   endtask

   // ---------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------
   initial begin
      tx_idle_pct = 8;
      rx_idle_pct = 79;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_plain_bytes();
      test_escape_forms();
      test_line_numbers();
      test_blank_squeeze();

      // slow receiver, then slow sender, then both at full rate
      test_random_text();
      tx_idle_pct = 79;
      rx_idle_pct = 8;
      test_random_text();
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      test_random_text();

      drain();
      repeat (20) @(posedge clock);
      if (pending_out_bytes.size() != 0) begin
         $display("%0t %0d expected items never arrived", $time, pending_out_bytes.size());
         errors++;
      end
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
